### hw/rtl/prq_pkg.sv
package prq_pkg;

	typedef enum logic [2:0] {
		CMD_PUSH_HEAD  = 3'd0,
		CMD_PUSH_TAIL  = 3'd1,
		CMD_REMOVE     = 3'd2,
		CMD_SET_STATUS = 3'd3,
		CMD_SCHEDULE   = 3'd4
	} cmd_t;

	localparam logic [1:0] TS_READY   = 2'd0;
	localparam logic [1:0] TS_RUNNING = 2'd1;
	localparam logic [1:0] TS_BLOCKED = 2'd2;

	typedef enum logic [2:0] {
		FS_IDLE,
		FS_EXEC,
		FS_TAIL,
		FS_SCAN,
		FS_FALLBK,
		FS_COMMIT
	} fsm_t;

	// write enables into the link tables
	typedef struct packed {
		logic tw;       // thread entry: next, prev, in-queue flag
		logic tw_meta;  // thread entry: level and cpu
		logic st0;
		logic st1;
		logic nl;
		logic pl;
		logic hd;
	} tbl_we_t;

endpackage

### hw/rtl/prq_tables.sv
module prq_tables #(
	parameter int NT = 16,
	parameter int NL = 8,
	parameter int NC = 4,
	localparam int TW = $clog2(NT),
	localparam int LKW = TW + 1,
	localparam int LW = (NL > 1) ? $clog2(NL) : 1,
	localparam int CW = (NC > 1) ? $clog2(NC) : 1,
	localparam int SLOTS = NC * NL,
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  prq_pkg::tbl_we_t we,
	input  logic [TW-1:0]    tw_id,
	input  logic [LKW-1:0]   tw_next,
	input  logic [LKW-1:0]   tw_prev,
	input  logic [LW-1:0]    tw_level,
	input  logic [CW-1:0]    tw_cpu,
	input  logic             tw_inq,
	input  logic [TW-1:0]    st0_id,
	input  logic [1:0]       st0_val,
	input  logic [TW-1:0]    st1_id,
	input  logic [1:0]       st1_val,
	input  logic [TW-1:0]    nl_id,
	input  logic [LKW-1:0]   nl_val,
	input  logic [TW-1:0]    pl_id,
	input  logic [LKW-1:0]   pl_val,
	input  logic [SW-1:0]    hd_widx,
	input  logic [LKW-1:0]   hd_val,
	input  logic [TW-1:0]    rd_id,
	input  logic [SW-1:0]    hd_ridx,
	output logic [LKW-1:0]   rd_next,
	output logic [LKW-1:0]   rd_prev,
	output logic [LW-1:0]    rd_level,
	output logic [CW-1:0]    rd_cpu,
	output logic [1:0]       rd_state,
	output logic             rd_inq,
	output logic [LKW-1:0]   hd_rdata
);
	import prq_pkg::*;

	logic [LKW-1:0] next_q [NT];
	logic [LKW-1:0] prev_q [NT];
	logic [LW-1:0]  level_q [NT];
	logic [CW-1:0]  cpu_q [NT];
	logic [1:0]     state_q [NT];
	logic           inq_q [NT];
	logic [LKW-1:0] head_q [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NT; i++) begin
				next_q[i]  <= '0;
				prev_q[i]  <= '0;
				level_q[i] <= '0;
				cpu_q[i]   <= '0;
				state_q[i] <= TS_READY;
				inq_q[i]   <= 1'b0;
			end
			for (int i = 0; i < SLOTS; i++) begin
				head_q[i] <= '0;
			end
		end else begin
			if (we.tw) begin
				next_q[tw_id] <= tw_next;
				prev_q[tw_id] <= tw_prev;
				inq_q[tw_id]  <= tw_inq;
			end
			if (we.tw_meta) begin
				level_q[tw_id] <= tw_level;
				cpu_q[tw_id]   <= tw_cpu;
			end
			if (we.nl)
				next_q[nl_id] <= nl_val;
			if (we.pl)
				prev_q[pl_id] <= pl_val;
			if (we.st0)
				state_q[st0_id] <= st0_val;
			if (we.st1)
				state_q[st1_id] <= st1_val;
			if (we.hd)
				head_q[hd_widx] <= hd_val;
		end
	end

	assign rd_next  = next_q[rd_id];
	assign rd_prev  = prev_q[rd_id];
	assign rd_level = level_q[rd_id];
	assign rd_cpu   = cpu_q[rd_id];
	assign rd_state = state_q[rd_id];
	assign rd_inq   = inq_q[rd_id];
	assign hd_rdata = head_q[hd_ridx];

endmodule

### hw/rtl/priority_ready_queue_scheduler_unit.sv
// Priority ready-queue scheduler for several CPUs.
// A request is taken when start is high and busy is low; the fields command,
// cpu, thread, priority_req and new_status are sampled at that edge. busy
// stays high until the result is issued. The result appears on next_thread,
// prev_thread, switched, idle and error for exactly one cycle with done high;
// the receiver cannot stall, so nothing waits.
// Push head, remove and set status finish in the execute state. Push tail
// into a non-empty list then walks the list to its last thread
// (one link read per cycle). Schedule walks the CPU's lists from the top
// level down, one list head or one list node per cycle, then falls back
// or commits. One request is in flight at a time. The shared table read
// port (one thread entry and one list head per cycle) sets the pace of
// these walks.
// Reset clears all lists, links and queue flags, sets every thread ready and
// leaves every CPU with no current thread; the block is ready at once.
module priority_ready_queue_scheduler_unit #(
	parameter int NUM_THREADS = 16,
	parameter int NUM_LEVELS  = 8,
	parameter int NUM_CPUS    = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] command,
	input  logic [1:0] cpu,
	input  logic [3:0] thread,
	input  logic [2:0] priority_req,
	input  logic [1:0] new_status,
	output logic       done,
	output logic [3:0] next_thread,
	output logic [3:0] prev_thread,
	output logic       switched,
	output logic       idle,
	output logic       error
);
	import prq_pkg::*;

	localparam int TW = $clog2(NUM_THREADS);
	localparam int LKW = TW + 1;
	localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int SLOTS = NUM_CPUS * NUM_LEVELS;
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [LW-1:0] TOP_LVL = LW'(NUM_LEVELS - 1);

	function automatic logic [SW-1:0] slot_of(logic [CW-1:0] c, logic [LW-1:0] l);
		return SW'(32'(c) * NUM_LEVELS + 32'(l));
	endfunction

	fsm_t fs_q, fs_d;
	logic [2:0]     cmd_q;
	logic [CW-1:0]  cpu_q;
	logic           cpu_ok_q;
	logic [TW-1:0]  tid_q;
	logic           tid_ok_q;
	logic [LW-1:0]  lv_q;
	logic [1:0]     nst_q;
	logic [LW-1:0]  lvl_q;
	logic [LKW-1:0] lk_q;
	logic [TW-1:0]  cur_q;
	logic [TW-1:0]  pick_q;
	logic [LKW-1:0] run_q [NUM_CPUS];
	logic           done_q;
	logic [3:0]     nxt_q, prv_q;
	logic           sw_q, idl_q, err_q;

	tbl_we_t        we;
	logic [TW-1:0]  tw_id, st0_id, st1_id, nl_id, pl_id, rd_id;
	logic [LKW-1:0] tw_next, tw_prev, nl_val, pl_val, hd_val;
	logic           tw_inq;
	logic [1:0]     st0_val, st1_val;
	logic [SW-1:0]  hd_widx, hd_ridx;
	logic [LKW-1:0] rd_next, rd_prev, hd_rdata;
	logic [LW-1:0]  rd_level;
	logic [CW-1:0]  rd_cpu;
	logic [1:0]     rd_state;
	logic           rd_inq;

	logic           fin;
	logic [3:0]     r_nxt, r_prv;
	logic           r_sw, r_idl, r_err;
	logic           run_we;
	logic [LKW-1:0] run_cur, me;
	logic           accept;
	logic           pick_hit;

	assign accept  = start && !busy;
	assign busy    = (fs_q != FS_IDLE);
	assign run_cur = run_q[cpu_q];
	assign me      = {1'b1, tid_q};
	assign pick_hit = lk_q[TW] && rd_state == TS_READY
		&& !(run_cur[TW] && run_cur[TW-1:0] == lk_q[TW-1:0]);

	prq_tables #(.NT(NUM_THREADS), .NL(NUM_LEVELS), .NC(NUM_CPUS)) u_tables (
		.clk(clk), .arst_n(arst_n), .we(we),
		.tw_id(tw_id), .tw_next(tw_next), .tw_prev(tw_prev),
		.tw_level(lv_q), .tw_cpu(cpu_q), .tw_inq(tw_inq),
		.st0_id(st0_id), .st0_val(st0_val), .st1_id(st1_id), .st1_val(st1_val),
		.nl_id(nl_id), .nl_val(nl_val), .pl_id(pl_id), .pl_val(pl_val),
		.hd_widx(hd_widx), .hd_val(hd_val), .rd_id(rd_id), .hd_ridx(hd_ridx),
		.rd_next(rd_next), .rd_prev(rd_prev), .rd_level(rd_level), .rd_cpu(rd_cpu),
		.rd_state(rd_state), .rd_inq(rd_inq), .hd_rdata(hd_rdata)
	);

	// read port addressing
	always_comb begin
		rd_id   = tid_q;
		hd_ridx = slot_of(cpu_q, lv_q);
		case (fs_q)
			FS_TAIL:   rd_id = cur_q;
			FS_SCAN: begin
				rd_id   = lk_q[TW-1:0];
				hd_ridx = slot_of(cpu_q, lvl_q);
			end
			FS_FALLBK: rd_id = run_cur[TW-1:0];
			FS_COMMIT: rd_id = run_cur[TW-1:0];
			default:   rd_id = tid_q;
		endcase
	end

	// next state
	always_comb begin
		fs_d = fs_q;
		case (fs_q)
			FS_IDLE:
				if (accept)
					fs_d = FS_EXEC;
			FS_EXEC: begin
				fs_d = FS_IDLE;
				if (cmd_q == CMD_PUSH_TAIL && tid_ok_q && cpu_ok_q && !rd_inq && hd_rdata[TW])
					fs_d = FS_TAIL;
				if (cmd_q == CMD_SCHEDULE && cpu_ok_q)
					fs_d = FS_SCAN;
			end
			FS_TAIL:
				if (!rd_next[TW])
					fs_d = FS_IDLE;
			FS_SCAN:
				if (lk_q[TW]) begin
					if (pick_hit)
						fs_d = FS_COMMIT;
					else if (!rd_next[TW] && lvl_q == '0)
						fs_d = FS_FALLBK;
				end else if (!hd_rdata[TW] && lvl_q == '0) begin
					fs_d = FS_FALLBK;
				end
			FS_FALLBK: fs_d = FS_IDLE;
			FS_COMMIT: fs_d = FS_IDLE;
			default:   fs_d = FS_IDLE;
		endcase
	end

	// table writes and results
	always_comb begin
		we      = '0;
		tw_id   = tid_q;
		tw_next = '0;
		tw_prev = '0;
		tw_inq  = 1'b0;
		st0_id  = tid_q;
		st0_val = TS_READY;
		st1_id  = pick_q;
		st1_val = TS_RUNNING;
		nl_id   = rd_prev[TW-1:0];
		nl_val  = rd_next;
		pl_id   = rd_next[TW-1:0];
		pl_val  = rd_prev;
		hd_widx = slot_of(cpu_q, lv_q);
		hd_val  = me;
		fin     = 1'b0;
		r_nxt   = '0;
		r_prv   = '0;
		r_sw    = 1'b0;
		r_idl   = 1'b0;
		r_err   = 1'b0;
		run_we  = 1'b0;
		case (fs_q)
			FS_EXEC: begin
				fin = 1'b1;
				case (cmd_q)
					CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
						if (!tid_ok_q || !cpu_ok_q || rd_inq) begin
							r_err = 1'b1;
						end else if (!hd_rdata[TW]) begin
							we.tw = 1'b1; we.tw_meta = 1'b1; we.st0 = 1'b1; we.hd = 1'b1;
							tw_inq = 1'b1;
						end else if (cmd_q == CMD_PUSH_HEAD) begin
							we.tw = 1'b1; we.tw_meta = 1'b1; we.st0 = 1'b1; we.hd = 1'b1;
							we.pl = 1'b1;
							tw_inq  = 1'b1;
							tw_next = hd_rdata;
							pl_id   = hd_rdata[TW-1:0];
							pl_val  = me;
						end else begin
							fin = 1'b0;
						end
					end
					CMD_REMOVE: begin
						if (!tid_ok_q || !rd_inq) begin
							r_err = 1'b1;
						end else begin
							we.tw = 1'b1;
							if (rd_prev[TW])
								we.nl = 1'b1;
							else
								we.hd = 1'b1;
							hd_widx = slot_of(rd_cpu, rd_level);
							hd_val  = rd_next;
							we.pl   = rd_next[TW];
						end
					end
					CMD_SET_STATUS: begin
						we.st0  = tid_ok_q && (nst_q == TS_READY || nst_q == TS_RUNNING
							|| nst_q == TS_BLOCKED);
						st0_val = nst_q;
					end
					CMD_SCHEDULE: begin
						if (!cpu_ok_q)
							r_idl = 1'b1;
						else
							fin = 1'b0;
					end
					default: ;
				endcase
			end
			FS_TAIL:
				if (!rd_next[TW]) begin
					fin = 1'b1;
					we.nl = 1'b1; we.tw = 1'b1; we.tw_meta = 1'b1; we.st0 = 1'b1;
					nl_id   = cur_q;
					nl_val  = me;
					tw_inq  = 1'b1;
					tw_prev = {1'b1, cur_q};
				end
			FS_FALLBK: begin
				fin = 1'b1;
				if (run_cur[TW] && rd_state == TS_READY) begin
					r_nxt = 4'(run_cur[TW-1:0]);
					r_prv = 4'(run_cur[TW-1:0]);
				end else begin
					r_idl = 1'b1;
				end
			end
			FS_COMMIT: begin
				fin    = 1'b1;
				r_sw   = 1'b1;
				r_nxt  = 4'(pick_q);
				run_we = 1'b1;
				we.st1 = 1'b1;
				if (run_cur[TW]) begin
					r_prv  = 4'(run_cur[TW-1:0]);
					st0_id = run_cur[TW-1:0];
					we.st0 = (rd_state == TS_RUNNING);
				end else begin
					r_prv = 4'(pick_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q   <= FS_IDLE;
			done_q <= 1'b0;
			for (int i = 0; i < NUM_CPUS; i++)
				run_q[i] <= '0;
		end else begin
			fs_q   <= fs_d;
			done_q <= fin;
			if (run_we)
				run_q[cpu_q] <= {1'b1, pick_q};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= command;
			cpu_q    <= CW'(cpu);
			cpu_ok_q <= (32'(cpu) < NUM_CPUS);
			tid_q    <= TW'(thread);
			tid_ok_q <= (32'(thread) < NUM_THREADS);
			lv_q     <= (32'(priority_req) >= NUM_LEVELS) ? TOP_LVL : LW'(priority_req);
			nst_q    <= new_status;
			lvl_q    <= TOP_LVL;
			lk_q     <= '0;
		end
		if (fs_q == FS_EXEC)
			cur_q <= hd_rdata[TW-1:0];
		if (fs_q == FS_TAIL && rd_next[TW])
			cur_q <= rd_next[TW-1:0];
		if (fs_q == FS_SCAN) begin
			if (lk_q[TW]) begin
				if (pick_hit) begin
					pick_q <= lk_q[TW-1:0];
				end else if (rd_next[TW]) begin
					lk_q <= rd_next;
				end else begin
					lk_q <= '0;
					if (lvl_q != '0)
						lvl_q <= lvl_q - 1'b1;
				end
			end else if (hd_rdata[TW]) begin
				lk_q <= hd_rdata;
			end else if (lvl_q != '0) begin
				lvl_q <= lvl_q - 1'b1;
			end
		end
		if (fin) begin
			nxt_q <= r_nxt;
			prv_q <= r_prv;
			sw_q  <= r_sw;
			idl_q <= r_idl;
			err_q <= r_err;
		end
	end

	assign done        = done_q;
	assign next_thread = nxt_q;
	assign prev_thread = prv_q;
	assign switched    = sw_q;
	assign idle        = idl_q;
	assign error       = err_q;

endmodule

### sim/prq_checker.sv
module prq_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [2:0] command,
	input  logic [1:0] cpu,
	input  logic [3:0] thread,
	input  logic [2:0] priority_req,
	input  logic [1:0] new_status,
	input  logic       done,
	input  logic [3:0] next_thread,
	input  logic [3:0] prev_thread,
	input  logic       switched,
	input  logic       idle,
	input  logic       error,
	output int         fail_count,
	output int         pending
);
	import prq_pkg::*;

	typedef struct packed {
		logic [3:0] next_thread;
		logic [3:0] prev_thread;
		logic       switched;
		logic       idle;
		logic       error;
	} sched_result_t;

	// link: bit 4 valid, bits 3:0 thread id
	logic [4:0] head_tbl [32];
	logic [4:0] nxt_tbl [16];
	logic [4:0] prv_tbl [16];
	logic [2:0] lvl_tbl [16];
	logic [1:0] stat_tbl [16];
	logic       queued [16];
	logic [1:0] owner_cpu [16];
	logic [4:0] current [4];

	sched_result_t expected_results [$];

	task automatic link_in(input logic [1:0] c, input logic [3:0] t, input logic [2:0] lv,
			input logic at_tail);
		logic [4:0] slot;
		logic [4:0] h;
		logic [3:0] walk;
		slot = {c, lv};
		h = head_tbl[slot];
		stat_tbl[t] = TS_READY;
		lvl_tbl[t] = lv;
		owner_cpu[t] = c;
		queued[t] = 1'b1;
		nxt_tbl[t] = '0;
		prv_tbl[t] = '0;
		if (!h[4]) begin
			head_tbl[slot] = {1'b1, t};
		end else if (!at_tail) begin
			nxt_tbl[t] = h;
			prv_tbl[h[3:0]] = {1'b1, t};
			head_tbl[slot] = {1'b1, t};
		end else begin
			walk = h[3:0];
			for (int s = 0; s < 16 && nxt_tbl[walk][4]; s++)
				walk = nxt_tbl[walk][3:0];
			nxt_tbl[walk] = {1'b1, t};
			prv_tbl[t] = {1'b1, walk};
		end
	endtask

	task automatic unlink(input logic [3:0] t);
		logic [4:0] p;
		logic [4:0] n;
		p = prv_tbl[t];
		n = nxt_tbl[t];
		if (p[4])
			nxt_tbl[p[3:0]] = n;
		else
			head_tbl[{owner_cpu[t], lvl_tbl[t]}] = n;
		if (n[4])
			prv_tbl[n[3:0]] = p;
		nxt_tbl[t] = '0;
		prv_tbl[t] = '0;
		queued[t] = 1'b0;
	endtask

	function automatic logic [4:0] choose_thread(input logic [1:0] c);
		logic [4:0] cur;
		logic [4:0] l;
		cur = current[c];
		for (int lv = 7; lv >= 0; lv--) begin
			l = head_tbl[{c, 3'(lv)}];
			for (int s = 0; s < 16 && l[4]; s++) begin
				if (!(cur[4] && cur[3:0] == l[3:0]) && stat_tbl[l[3:0]] == TS_READY)
					return l;
				l = nxt_tbl[l[3:0]];
			end
		end
		if (cur[4] && stat_tbl[cur[3:0]] == TS_READY)
			return cur;
		return '0;
	endfunction

	task automatic predict_request(output sched_result_t r);
		logic [4:0] ch;
		logic [4:0] cur;
		r = '0;
		case (command)
			CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
				if (queued[thread])
					r.error = 1'b1;
				else
					link_in(cpu, thread, priority_req, command == CMD_PUSH_TAIL);
			end
			CMD_REMOVE: begin
				if (!queued[thread])
					r.error = 1'b1;
				else
					unlink(thread);
			end
			CMD_SET_STATUS: begin
				if (new_status <= TS_BLOCKED)
					stat_tbl[thread] = new_status;
			end
			CMD_SCHEDULE: begin
				ch = choose_thread(cpu);
				cur = current[cpu];
				if (!ch[4]) begin
					r.idle = 1'b1;
				end else if (cur[4] && cur[3:0] == ch[3:0]) begin
					r.next_thread = ch[3:0];
					r.prev_thread = ch[3:0];
				end else begin
					r.next_thread = ch[3:0];
					r.prev_thread = cur[4] ? cur[3:0] : ch[3:0];
					if (cur[4] && stat_tbl[cur[3:0]] == TS_RUNNING)
						stat_tbl[cur[3:0]] = TS_READY;
					stat_tbl[ch[3:0]] = TS_RUNNING;
					current[cpu] = ch;
					r.switched = 1'b1;
				end
			end
			default: ;
		endcase
	endtask

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		sched_result_t exp_r;
		sched_result_t got;
		if (!arst_n) begin
			for (int i = 0; i < 32; i++)
				head_tbl[i] = '0;
			for (int i = 0; i < 16; i++) begin
				nxt_tbl[i] = '0;
				prv_tbl[i] = '0;
				lvl_tbl[i] = '0;
				stat_tbl[i] = TS_READY;
				queued[i] = 1'b0;
				owner_cpu[i] = '0;
			end
			for (int i = 0; i < 4; i++)
				current[i] = '0;
			expected_results.delete();
			fail_count = 0;
		end else begin
			// retire the older request first; it may finish on the edge a new one is taken
			if (done) begin
				got = '{next_thread, prev_thread, switched, idle, error};
				if (expected_results.size() == 0) begin
					$display("%0t: result with no request outstanding: %h", $time, got);
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (got.next_thread !== exp_r.next_thread) begin
						$display("%0t: next_thread expected %0d actual %0d", $time,
							exp_r.next_thread, got.next_thread);
						fail_count++;
					end
					if (got.prev_thread !== exp_r.prev_thread) begin
						$display("%0t: prev_thread expected %0d actual %0d", $time,
							exp_r.prev_thread, got.prev_thread);
						fail_count++;
					end
					if (got.switched !== exp_r.switched) begin
						$display("%0t: switched expected %b actual %b", $time,
							exp_r.switched, got.switched);
						fail_count++;
					end
					if (got.idle !== exp_r.idle) begin
						$display("%0t: idle expected %b actual %b", $time, exp_r.idle, got.idle);
						fail_count++;
					end
					if (got.error !== exp_r.error) begin
						$display("%0t: error expected %b actual %b", $time,
							exp_r.error, got.error);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				predict_request(exp_r);
				expected_results.push_back(exp_r);
			end
		end
	end

endmodule

### sim/testbench.sv
module testbench;
	import prq_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic [2:0] command = '0;
	logic [1:0] cpu = '0;
	logic [3:0] thread = '0;
	logic [2:0] priority_req = '0;
	logic [1:0] new_status = '0;
	logic       done;
	logic [3:0] next_thread;
	logic [3:0] prev_thread;
	logic       switched;
	logic       idle;
	logic       error;
	int         fail_count;
	int         pending;
	int         cycles = 0;
	logic       gaps_on = 1'b1;
	logic       queued_guess [16];

	always #4 clk = ~clk;

	priority_ready_queue_scheduler_unit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
		.cpu(cpu), .thread(thread), .priority_req(priority_req), .new_status(new_status),
		.done(done), .next_thread(next_thread), .prev_thread(prev_thread),
		.switched(switched), .idle(idle), .error(error)
	);

	prq_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
		.cpu(cpu), .thread(thread), .priority_req(priority_req), .new_status(new_status),
		.done(done), .next_thread(next_thread), .prev_thread(prev_thread),
		.switched(switched), .idle(idle), .error(error),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("FAILURE");
			$finish;
		end
	end

	// drives one request, waits for it to be taken, then maybe leaves a gap
	task automatic issue(input logic [2:0] cmd, input logic [1:0] c, input logic [3:0] t,
			input logic [2:0] pri, input logic [1:0] st);
		command <= cmd;
		cpu <= c;
		thread <= t;
		priority_req <= pri;
		new_status <= st;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (cmd == CMD_PUSH_HEAD || cmd == CMD_PUSH_TAIL)
			queued_guess[t] = 1'b1;
		else if (cmd == CMD_REMOVE)
			queued_guess[t] = 1'b0;
		if (gaps_on && $urandom_range(3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(16, 1)) @(posedge clk);
		end
	endtask

	function automatic logic [3:0] pick_id(input logic want_queued);
		logic [3:0] t;
		for (int i = 0; i < 8; i++) begin
			t = 4'($urandom);
			if (queued_guess[t] == want_queued)
				return t;
		end
		return t;
	endfunction

	task automatic random_request();
		int sel;
		sel = $urandom_range(99);
		if (sel < 30)
			issue($urandom_range(1) ? CMD_PUSH_TAIL : CMD_PUSH_HEAD, 2'($urandom),
				$urandom_range(9) == 0 ? 4'($urandom) : pick_id(1'b0),
				3'($urandom), 2'($urandom));
		else if (sel < 45)
			issue(CMD_REMOVE, 2'($urandom),
				$urandom_range(9) == 0 ? 4'($urandom) : pick_id(1'b1),
				3'($urandom), 2'($urandom));
		else if (sel < 60)
			issue(CMD_SET_STATUS, 2'($urandom), 4'($urandom), 3'($urandom),
				$urandom_range(9) == 0 ? 2'd3 : 2'($urandom_range(2)));
		else if (sel < 96)
			issue(CMD_SCHEDULE, 2'($urandom), 4'($urandom), 3'($urandom), 2'($urandom));
		else
			issue(3'($urandom_range(7, 5)), 2'($urandom), 4'($urandom), 3'($urandom),
				2'($urandom));
	endtask

	initial begin
		for (int i = 0; i < 16; i++)
			queued_guess[i] = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(CMD_SCHEDULE, 2'd0, 4'd0, 3'd0, 2'd0);       // nothing queued: idle
		issue(CMD_PUSH_HEAD, 2'd3, 4'd15, 3'd7, 2'd3);
		issue(CMD_PUSH_TAIL, 2'd3, 4'd0, 3'd7, 2'd0);
		issue(CMD_PUSH_TAIL, 2'd3, 4'd5, 3'd7, 2'd0);
		issue(CMD_PUSH_HEAD, 2'd3, 4'd6, 3'd0, 2'd0);
		issue(CMD_PUSH_HEAD, 2'd0, 4'd15, 3'd2, 2'd0);     // already queued: error
		issue(CMD_REMOVE, 2'd0, 4'd9, 3'd0, 2'd0);         // not queued: error
		issue(CMD_SCHEDULE, 2'd3, 4'd0, 3'd0, 2'd0);
		issue(CMD_SCHEDULE, 2'd3, 4'd0, 3'd0, 2'd0);
		issue(CMD_SET_STATUS, 2'd0, 4'd0, 3'd0, 2'd2);
		issue(CMD_SET_STATUS, 2'd0, 4'd5, 3'd0, 2'd3);     // status three ignored
		issue(CMD_SET_STATUS, 2'd0, 4'd6, 3'd0, 2'd1);
		issue(CMD_SCHEDULE, 2'd3, 4'd0, 3'd0, 2'd0);
		issue(CMD_REMOVE, 2'd1, 4'd0, 3'd0, 2'd0);         // middle of list
		issue(CMD_REMOVE, 2'd2, 4'd15, 3'd0, 2'd0);        // head of list
		issue(CMD_SCHEDULE, 2'd3, 4'd0, 3'd0, 2'd0);
		issue(CMD_SCHEDULE, 2'd3, 4'd0, 3'd0, 2'd0);       // no other ready thread, current one running: idle
		issue(CMD_SET_STATUS, 2'd0, 4'd5, 3'd0, 2'd2);
		issue(CMD_SCHEDULE, 2'd3, 4'd0, 3'd0, 2'd0);
		issue(3'd5, 2'd1, 4'd1, 3'd1, 2'd1);
		issue(3'd6, 2'd2, 4'd2, 3'd2, 2'd2);
		issue(3'd7, 2'd3, 4'd3, 3'd3, 2'd3);

		for (int n = 0; n < 1650; n++) begin
			if (n == 1450)
				gaps_on = 1'b0;
			random_request();
		end
		start <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### files.f
hw/rtl/prq_pkg.sv
hw/rtl/prq_tables.sv
hw/rtl/priority_ready_queue_scheduler_unit.sv
sim/prq_checker.sv
sim/testbench.sv
